// ----- rtl/core/encoder_period_speed_meter_core_defines.svh -----
// ----------------------------------------------------------------------------
// encoder period speed meter - assertion macros
// shared concurrent assertion forms for the core rtl
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_SPEED_METER_CORE_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_METER_CORE_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define EPSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define EPSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/epsm_pkg.sv -----
// ----------------------------------------------------------------------------
// epsm_pkg
// shared types and constants of the encoder period speed meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epsm_pkg;

    localparam int unsigned CHANNELS = 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_REV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KEEP      = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] RST_SLOTS_PER_REV    = 16'd50;
    localparam logic [23:0] RST_TICK_RATE        = 24'd50000;
    localparam logic [16:0] RST_TIMER_PERIOD     = 17'd20000;
    localparam logic [31:0] RST_GLITCH_THRESHOLD = 32'd600;
    localparam logic [8:0]  RST_FILTER_KEEP      = 9'd179;

    localparam logic [8:0] KEEP_FULL = 9'd256;

    // transaction modes
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_WRAP = 1'b1;

    // shared multiplier
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // divider: (tick_rate << 16) / (slots * period)
    localparam int unsigned DIV_NUM_W = 40;
    localparam int unsigned DIV_DEN_W = 48;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- rtl/core/epsm_mul.sv -----
// ----------------------------------------------------------------------------
// epsm_mul
// shared registered 32x17 multiplier, one product per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epsm_mul (
    input  wire logic                           i_clk,
    input  wire logic [epsm_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic [epsm_pkg::MUL_B_W-1:0]   i_b,
    output logic      [epsm_pkg::MUL_P_W-1:0]   o_p
);
    import epsm_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- rtl/core/epsm_div.sv -----
// ----------------------------------------------------------------------------
// epsm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epsm_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [epsm_pkg::DIV_NUM_W-1:0]   i_num,
    input  wire logic [epsm_pkg::DIV_DEN_W-1:0]   i_den,
    output logic      [epsm_pkg::DIV_NUM_W-1:0]   o_quot,
    output epsm_pkg::t_div_stat                   o_stat
);
    import epsm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   n_shift;
    logic [DIV_DEN_W:0]   n_diff;
    logic                 n_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        n_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_rem   = n_ge ? n_diff[DIV_DEN_W-1:0] : n_shift[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // a zero divisor leaves every quotient bit set, which saturates upstream
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], n_ge};
        end
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/encoder_period_speed_meter_core.sv -----
// An edge transaction measures the period since the previous edge of its channel,
// including counter wraps, and returns one result: accepted edges pass the multiplier,
// the 40-step restoring divider that forms the Q16.16 speed and the filter; glitches
// skip from the period check to the output stage; wraps only count. The input stalls
// while a transaction is in progress and, at the end, until the output register is
// free; a pending result does not block the next transaction.
// ----------------------------------------------------------------------------
// encoder_period_speed_meter_core
// two-channel encoder period and speed meter with glitch rejection and iir smoothing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_period_speed_meter_core_defines.svh"

module encoder_period_speed_meter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [epsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [epsm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic                              i_channel,
    input  wire logic [15:0]                       i_capture_count,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_channel,
    output logic                                   o_accepted,
    output logic      [31:0]                       o_period_ticks,
    output logic      [31:0]                       o_speed_raw,
    output logic      [31:0]                       o_speed_filtered
);
    import epsm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL_WRAP = 9'b000000010,
        S_PERIOD   = 9'b000000100,
        S_MUL_DEN  = 9'b000001000,
        S_DIV_GO   = 9'b000010000,
        S_DIV      = 9'b000100000,
        S_MUL_OLD  = 9'b001000000,
        S_MUL_RAW  = 9'b010000000,
        S_FILT     = 9'b100000000
    } t_state;

    // configuration registers
    logic [15:0] r_slots;
    logic [23:0] r_tick_rate;
    logic [16:0] r_timer_period;
    logic [31:0] r_glitch_thr;
    logic [8:0]  r_filter_keep;

    // measurement state
    t_state      r_state,                 n_state;
    logic [15:0] r_stamp_now [CHANNELS];
    logic [15:0] n_stamp_now [CHANNELS];
    logic [31:0] r_filt      [CHANNELS];
    logic [31:0] n_filt      [CHANNELS];
    logic [15:0] r_wrap,                  n_wrap;
    logic        r_ch,                    n_ch;
    logic [15:0] r_cap,                   n_cap;
    logic [31:0] r_period,                n_period;
    logic        r_ok,                    n_ok;
    logic [31:0] r_raw,                   n_raw;
    logic [39:0] r_acc,                   n_acc;
    logic        r_out_valid,             n_out_valid;
    logic        out_load;

    // shared units
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_quot;
    t_div_stat            div_stat;

    logic [8:0]  keep_sat;
    logic [8:0]  keep_inv;
    logic [31:0] period_calc;
    logic [39:0] filt_sum;
    logic        ch_ok;

    epsm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    epsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_tick_rate, 16'b0}),
        .i_den   (mul_p[DIV_DEN_W-1:0]),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    assign keep_sat    = (r_filter_keep > KEEP_FULL) ? KEEP_FULL : r_filter_keep;
    assign keep_inv    = KEEP_FULL - keep_sat;
    assign period_calc = {16'b0, r_cap} + mul_p[31:0] - {16'b0, r_stamp_now[r_ch]};
    assign filt_sum    = r_acc + mul_p[39:0];
    assign ch_ok       = (32'(i_channel) < CHANNELS);
    assign o_in_stall  = (r_state != S_IDLE);
    assign div_start   = (r_state == S_DIV_GO);

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MUL_WRAP: begin
                mul_a = {16'b0, r_wrap};
                mul_b = r_timer_period;
            end
            S_MUL_DEN: begin
                mul_a = r_period;
                mul_b = {1'b0, r_slots};
            end
            S_MUL_OLD: begin
                mul_a = r_filt[r_ch];
                mul_b = {8'b0, keep_sat};
            end
            // held through the final state so the product survives an output stall
            S_MUL_RAW, S_FILT: begin
                mul_a = r_raw;
                mul_b = {8'b0, keep_inv};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_stamp_now = r_stamp_now;
        n_filt      = r_filt;
        n_wrap      = r_wrap;
        n_ch        = r_ch;
        n_cap       = r_cap;
        n_period    = r_period;
        n_ok        = r_ok;
        n_raw       = r_raw;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_WRAP) begin
                        if (r_wrap != 16'hFFFF) begin
                            n_wrap = r_wrap + 16'd1;
                        end
                    end else if (ch_ok) begin
                        n_ch    = i_channel;
                        n_cap   = i_capture_count;
                        n_state = S_MUL_WRAP;
                    end
                end
            end
            S_MUL_WRAP: begin
                n_state = S_PERIOD;
            end
            S_PERIOD: begin
                n_period = period_calc;
                n_ok     = (period_calc > r_glitch_thr);
                if (period_calc > r_glitch_thr) begin
                    n_stamp_now[r_ch] = r_cap;
                    n_wrap            = '0;
                    n_state           = S_MUL_DEN;
                end else begin
                    // glitch: history stays as it was
                    n_raw   = '0;
                    n_state = S_FILT;
                end
            end
            S_MUL_DEN: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_raw   = (|div_quot[DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                    n_state = S_MUL_OLD;
                end
            end
            S_MUL_OLD: begin
                n_state = S_MUL_RAW;
            end
            S_MUL_RAW: begin
                n_acc   = mul_p[39:0];
                n_state = S_FILT;
            end
            S_FILT: begin
                // filter update happens once, when the result goes out
                if (!r_out_valid || !i_out_stall) begin
                    if (r_ok) begin
                        n_filt[r_ch] = filt_sum[39:8];
                    end
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots        <= RST_SLOTS_PER_REV;
            r_tick_rate    <= RST_TICK_RATE;
            r_timer_period <= RST_TIMER_PERIOD;
            r_glitch_thr   <= RST_GLITCH_THRESHOLD;
            r_filter_keep  <= RST_FILTER_KEEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOTS_PER_REV:    r_slots        <= i_cfg_data[15:0];
                CFG_TICK_RATE:        r_tick_rate    <= i_cfg_data[23:0];
                CFG_TIMER_PERIOD:     r_timer_period <= i_cfg_data[16:0];
                CFG_GLITCH_THRESHOLD: r_glitch_thr   <= i_cfg_data;
                CFG_FILTER_KEEP:      r_filter_keep  <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wrap      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_stamp_now[i] <= '0;
                r_filt[i]      <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
            r_stamp_now <= n_stamp_now;
            r_filt      <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_cap    <= n_cap;
        r_period <= n_period;
        r_ok     <= n_ok;
        r_raw    <= n_raw;
        r_acc    <= n_acc;
        if (out_load) begin
            o_out_channel    <= r_ch;
            o_accepted       <= r_ok;
            o_period_ticks   <= r_period;
            o_speed_raw      <= r_raw;
            o_speed_filtered <= r_ok ? filt_sum[39:8] : r_filt[r_ch];
        end
    end

    assign o_out_valid = r_out_valid;

    `EPSM_ASSERT(ast_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == S_FILT), "result raised outside the final state")
    `EPSM_ASSERT(ast_div_active, i_clk, i_rst_n, (r_state == S_DIV) |-> (div_stat.busy || div_stat.done), "waiting on an idle divider")
    `EPSM_ASSERT(ast_wrap_clear, i_clk, i_rst_n, (r_state == S_PERIOD && period_calc > r_glitch_thr) |=> (r_wrap == 16'd0), "wrap count not cleared after accepted edge")
    `EPSM_ASSERT(ast_glitch_raw, i_clk, i_rst_n, (o_out_valid && !o_accepted) |-> (o_speed_raw == 32'd0), "rejected transaction carries a speed")
    `EPSM_ASSERT_ALWAYS(ast_div_start_idle, i_clk, div_start |-> !div_stat.busy, "divider restarted while busy")

endmodule

`default_nettype wire

// ----- sim/encoder_period_speed_meter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_period_speed_meter_core_tb
// drives edge and wrap transactions through the speed meter, predicts each
// result with an independent period, speed and smoothing model or a fixed value, and compares
// every output transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------

module encoder_period_speed_meter_core_tb;

    import epsm_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 64;    // longer than the longest edge transaction
    localparam int unsigned STALL_LIMIT     = 2000;  // cycles without any transaction
    localparam int unsigned PHASES          = 7;
    localparam int unsigned ITEMS_PER_PHASE = 240;
    localparam int unsigned WRAP_BURST      = 40;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        ch;
        logic        acc;
        logic [31:0] period;
        logic [31:0] raw;
        logic [31:0] filt;
    } t_speed_rec;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 mode;
        logic                 ch;
        logic [15:0]          cap;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        logic                 known;
        t_speed_rec           want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode = MODE_EDGE;
    logic                  i_channel = 1'b0;
    logic [15:0]           i_capture_count = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_out_channel;
    logic                  o_accepted;
    logic [31:0]           o_period_ticks;
    logic [31:0]           o_speed_raw;
    logic [31:0]           o_speed_filtered;

    encoder_period_speed_meter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_channel        (i_channel),
        .i_capture_count  (i_capture_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_channel    (o_out_channel),
        .o_accepted       (o_accepted),
        .o_period_ticks   (o_period_ticks),
        .o_speed_raw      (o_speed_raw),
        .o_speed_filtered (o_speed_filtered)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor copy of registers and state
    logic [15:0] cf_slots;
    logic [23:0] cf_tick;
    logic [16:0] cf_tperiod;
    logic [31:0] cf_glitch;
    logic [8:0]  cf_keep;
    logic [15:0] st_now [2];
    logic [15:0] st_prev [2];
    logic [15:0] st_older [2];
    logic [15:0] wraps;
    logic [31:0] smooth [2];

    t_speed_rec speed_q [$];
    int unsigned fails = 0;
    bit          calm = 1'b0;
    bit          running = 1'b0;
    int unsigned idle_cycles = 0;

    task automatic reset_model();
        cf_slots   = 16'd50;
        cf_tick    = 24'd50000;
        cf_tperiod = 17'd20000;
        cf_glitch  = 32'd600;
        cf_keep    = 9'd179;
        wraps      = '0;
        for (int i = 0; i < 2; i++) begin
            st_now[i]   = '0;
            st_prev[i]  = '0;
            st_older[i] = '0;
            smooth[i]   = '0;
        end
    endtask

    task automatic predict_speed(input logic m, input logic ch, input logic [15:0] cap,
                                 output bit has, output t_speed_rec r);
        logic [63:0] span;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] acc;
        logic [8:0]  k;
        has = 1'b0;
        r   = '0;
        if (m == MODE_WRAP) begin
            if (wraps != 16'hFFFF) wraps = wraps + 16'd1;
        end else begin
            has = 1'b1;
            st_older[ch] = st_prev[ch];
            st_prev[ch]  = st_now[ch];
            st_now[ch]   = cap;
            span = 64'(st_now[ch]) + 64'(wraps) * 64'(cf_tperiod) - 64'(st_prev[ch]);
            r.ch     = ch;
            r.period = span[31:0];
            r.acc    = (r.period > cf_glitch);
            if (r.acc) begin
                num = {24'd0, cf_tick, 16'd0};
                den = 64'(cf_slots) * 64'(r.period);
                if (den == 64'd0) begin
                    r.raw = 32'hFFFF_FFFF;
                end else begin
                    quo   = num / den;
                    r.raw = (quo > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                end
                k   = (cf_keep > KEEP_FULL) ? KEEP_FULL : cf_keep;
                acc = 64'(k) * 64'(smooth[ch]) + (64'(KEEP_FULL) - 64'(k)) * 64'(r.raw);
                smooth[ch] = acc[39:8];
                wraps = '0;
            end else begin
                st_now[ch]  = st_prev[ch];
                st_prev[ch] = st_older[ch];
            end
            r.filt = smooth[ch];
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SLOTS_PER_REV:    cf_slots   = data[15:0];
            CFG_TICK_RATE:        cf_tick    = data[23:0];
            CFG_TIMER_PERIOD:     cf_tperiod = data[16:0];
            CFG_GLITCH_THRESHOLD: cf_glitch  = data;
            CFG_FILTER_KEEP:      cf_keep    = data[8:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every expected transaction is out and the core is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (speed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic m, input logic ch, input logic [15:0] cap,
                             input logic known, input t_speed_rec want);
        bit         has;
        t_speed_rec r;
        if (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= m;
        i_channel       <= ch;
        i_capture_count <= cap;
        do @(posedge i_clk); while (o_in_stall);
        predict_speed(m, ch, cap, has, r);
        if (has) speed_q.push_back(known ? want : r);
    endtask

    // random bits above the register width, which the core must drop
    function automatic logic [31:0] padded(input logic [31:0] v, input int unsigned w);
        logic [31:0] mask;
        mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        return (v & mask) | ($urandom & ~mask);
    endfunction

    function automatic t_dir_row item_row(input logic m, input logic ch, input logic [15:0] cap);
        t_dir_row d;
        d      = '0;
        d.kind = ROW_ITEM;
        d.mode = m;
        d.ch   = ch;
        d.cap  = cap;
        return d;
    endfunction

    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_dir_row d;
        d      = '0;
        d.kind = ROW_REG;
        d.idx  = idx;
        d.data = data;
        return d;
    endfunction

    task automatic random_setting();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = 32'd1;
            1: v = $urandom_range(1, 64);
            2: v = $urandom_range(1, 1000);
            3: v = $urandom;
            default: v = 32'd65535;
        endcase
        cfg_write(CFG_SLOTS_PER_REV, padded(v, 16));
        case ($urandom_range(3))
            0: v = $urandom_range(1, 1000);
            1: v = 32'd50000;
            2: v = $urandom;
            default: v = 32'h00FF_FFFF;
        endcase
        cfg_write(CFG_TICK_RATE, padded(v, 24));
        case ($urandom_range(2))
            0: v = $urandom_range(1, 65536);
            1: v = $urandom;
            default: v = 32'd20000;
        endcase
        cfg_write(CFG_TIMER_PERIOD, padded(v, 17));
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(0, 100);
            3, 4, 5, 6: v = $urandom_range(0, 3000);
            7: v = 32'd0;
            8: v = $urandom_range(0, 200000);
            default: v = $urandom;
        endcase
        cfg_write(CFG_GLITCH_THRESHOLD, v);
        case ($urandom_range(2))
            0: v = $urandom_range(0, 256);
            1: v = $urandom_range(0, 511);
            default: v = 32'd179;
        endcase
        cfg_write(CFG_FILTER_KEEP, padded(v, 9));
        if ($urandom_range(1)) cfg_write(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(2)), $urandom);
    endtask

    // output side: random stall, compare against the oldest prediction
    always @(posedge i_clk) begin : out_mon
        t_speed_rec want;
        i_out_stall <= !calm && ($urandom_range(99) < 37);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (speed_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected transaction ch %0d period %0h", $time,
                         o_out_channel, o_period_ticks);
            end else begin
                want = speed_q.pop_front();
                if ({o_out_channel, o_accepted} !== {want.ch, want.acc}) begin
                    fails++;
                    $display("%0t: channel/accepted expected %b%b actual %b%b", $time,
                             want.ch, want.acc, o_out_channel, o_accepted);
                end
                if (o_period_ticks !== want.period) begin
                    fails++;
                    $display("%0t: period expected %0h actual %0h", $time,
                             want.period, o_period_ticks);
                end
                if (o_speed_raw !== want.raw) begin
                    fails++;
                    $display("%0t: speed_raw expected %0h actual %0h", $time,
                             want.raw, o_speed_raw);
                end
                if (o_speed_filtered !== want.filt) begin
                    fails++;
                    $display("%0t: speed_filtered expected %0h actual %0h", $time,
                             want.filt, o_speed_filtered);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("encoder_period_speed_meter_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row    dir_rows [$];
        t_dir_row    d;
        logic [15:0] last_cap [2];
        logic [15:0] delta;
        logic        ch;
        int unsigned pick;

        reset_model();
        last_cap[0] = '0;
        last_cap[1] = '0;

        // right after reset: zero period and a period equal to the threshold are glitches
        d = item_row(MODE_EDGE, 1'b0, 16'd0);
        d.known = 1'b1;
        d.want  = '{ch: 1'b0, acc: 1'b0, period: 32'd0, raw: 32'd0, filt: 32'd0};
        dir_rows.push_back(d);
        d = item_row(MODE_EDGE, 1'b0, 16'd600);
        d.known = 1'b1;
        d.want  = '{ch: 1'b0, acc: 1'b0, period: 32'd600, raw: 32'd0, filt: 32'd0};
        dir_rows.push_back(d);
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd601));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'hFFFF));
        dir_rows.push_back(item_row(MODE_WRAP, 1'b1, 16'hFFFF));
        dir_rows.push_back(item_row(MODE_WRAP, 1'b0, 16'h0000));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd0));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'hFFFF));
        // zero slots, junk above the field
        dir_rows.push_back(reg_row(CFG_SLOTS_PER_REV, 32'hABCD_0000));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd40000));
        // keep above full weight
        dir_rows.push_back(reg_row(CFG_FILTER_KEEP, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd45000));
        dir_rows.push_back(reg_row(CFG_FILTER_KEEP, 32'd0));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'd100));
        // quotient overflow and zero threshold
        dir_rows.push_back(reg_row(CFG_SLOTS_PER_REV, 32'd1));
        dir_rows.push_back(reg_row(CFG_TICK_RATE, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_GLITCH_THRESHOLD, 32'd0));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'd101));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'd101));
        // maximum threshold rejects everything
        dir_rows.push_back(reg_row(CFG_SLOTS_PER_REV, 32'd65535));
        dir_rows.push_back(reg_row(CFG_TICK_RATE, 32'd1));
        dir_rows.push_back(reg_row(CFG_GLITCH_THRESHOLD, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd0));
        dir_rows.push_back(reg_row(CFG_GLITCH_THRESHOLD, 32'd0));
        dir_rows.push_back(reg_row(CFG_TICK_RATE, 32'h0000_0000));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd5000));
        // writes to undecoded indexes change nothing
        dir_rows.push_back(reg_row(CFG_SPARE_LO, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_SPARE_HI, 32'd0));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'd9000));
        dir_rows.push_back(reg_row(CFG_TIMER_PERIOD, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_GLITCH_THRESHOLD, 32'd1000));
        dir_rows.push_back(reg_row(CFG_FILTER_KEEP, 32'd256));
        dir_rows.push_back(reg_row(CFG_TICK_RATE, 32'h00FF_FFFF));
        dir_rows.push_back(reg_row(CFG_SLOTS_PER_REV, 32'd50));
        dir_rows.push_back(item_row(MODE_WRAP, 1'b0, 16'h5555));
        dir_rows.push_back(item_row(MODE_WRAP, 1'b1, 16'hAAAA));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 16'd0));
        dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 16'hFFFF));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                settle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].mode, dir_rows[i].ch, dir_rows[i].cap,
                          dir_rows[i].known, dir_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            random_setting();
            calm = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                ch   = 1'($urandom_range(1));
                if (pick < 12) begin
                    send_item(MODE_WRAP, ch, 16'($urandom), 1'b0, '0);
                end else if (pick < 88) begin
                    // steady encoder: timestamps move forward by a plausible amount
                    case ($urandom_range(3))
                        0: delta = 16'($urandom_range(0, 40));
                        1: delta = 16'($urandom_range(0, 3000));
                        2: delta = 16'($urandom);
                        default: delta = cf_tperiod[15:0];
                    endcase
                    last_cap[ch] = last_cap[ch] + delta;
                    send_item(MODE_EDGE, ch, last_cap[ch], 1'b0, '0);
                end else begin
                    send_item(1'($urandom_range(1)), ch, 16'($urandom), 1'b0, '0);
                end
                if ($urandom_range(199) == 0) settle();
            end
        end
        calm = 1'b0;

        // back to back wraps with the widest timer period
        settle();
        cfg_write(CFG_TIMER_PERIOD, 32'h0001_FFFF);
        cfg_write(CFG_GLITCH_THRESHOLD, 32'd0);
        calm = 1'b1;
        repeat (WRAP_BURST) send_item(MODE_WRAP, 1'($urandom_range(1)), 16'($urandom), 1'b0, '0);
        calm = 1'b0;
        send_item(MODE_EDGE, 1'b0, 16'($urandom), 1'b0, '0);
        send_item(MODE_EDGE, 1'b1, 16'($urandom), 1'b0, '0);

        settle();
        running = 1'b0;
        if (fails == 0 && speed_q.size() == 0)
            $display("encoder_period_speed_meter_core regression: pass");
        else
            $display("encoder_period_speed_meter_core regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/epsm_pkg.sv
rtl/core/epsm_mul.sv
rtl/core/epsm_div.sv
rtl/core/encoder_period_speed_meter_core.sv
sim/encoder_period_speed_meter_core_tb.sv
